// ----- hdl/lambda_term_byte_tokenizer_macros.svh -----
// Assertion macros for the tokenizer; clk and rst_n come from the using module.
`ifndef LAMBDA_TERM_BYTE_TOKENIZER_MACROS_SVH
`define LAMBDA_TERM_BYTE_TOKENIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LTBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LTBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LTBT_ASSERT_IMP(lbl, ante, cons, msg)
`define LTBT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/ltbt_pkg.sv -----
package ltbt_pkg;

  localparam int LINE_WIDTH_DEF = 16;
  localparam logic [15:0] FIRST_LINE_RST = 16'd1;

  localparam int MAX_RES   = 3;
  localparam int RES_CNT_W = 2;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_FIRST_LINE = 1'b0;

  localparam logic [7:0] LEAD_BYTE = 8'hCE;
  localparam logic [7:0] TAIL_BYTE = 8'hBB;
  localparam logic [7:0] CONT_LOW  = 8'h80;
  localparam logic [7:0] CONT_HIGH = 8'hBF;

  localparam logic [7:0] BYTE_SP    = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_FF    = 8'h0C;
  localparam logic [7:0] BYTE_VT    = 8'h0B;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_HASH  = 8'h23;
  localparam logic [7:0] BYTE_DOT   = 8'h2E;
  localparam logic [7:0] BYTE_LPAR  = 8'h28;
  localparam logic [7:0] BYTE_RPAR  = 8'h29;
  localparam logic [7:0] BYTE_EQ    = 8'h3D;
  localparam logic [7:0] BYTE_BSL   = 8'h5C;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  typedef enum logic [3:0] {
    TK_END       = 4'd0,
    TK_NEWLINE   = 4'd1,
    TK_DOT       = 4'd2,
    TK_LPAREN    = 4'd3,
    TK_RPAREN    = 4'd4,
    TK_EQUALS    = 4'd5,
    TK_LAMBDA    = 4'd6,
    TK_NAMEBYTE  = 4'd7,
    TK_NAMEEND   = 4'd8,
    TK_TRUNC     = 4'd9,
    TK_DIGITNAME = 4'd10
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDLE_CE = 3'd2,
    MODE_NAME    = 3'd3,
    MODE_NAME_CE = 3'd4
  } scan_mode_t;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] line;
    logic [7:0]  ch;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [15:0] value;
  } cfg_wr_t;

endpackage

// ----- hdl/lambda_term_byte_tokenizer.sv -----
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/in_stall  in_byte, in_at_end
// out_      output     out_valid/out_stall out_token_kind, out_line_number,
//                                          out_name_char, out_last_of_run
// cfg       APB slave  psel/penable/pready paddr, pwdata, prdata
//
// One input item is decoded per cycle; its zero to three results enter a
// four-entry result queue in the same cycle and leave one per cycle while out_stall is low.
// Each result is registered in the queue before it reaches the output.
// The input stalls while the queue has no room for three more results.
// Synchronous active-low reset; no clearing pass, ready right after reset.
module lambda_term_byte_tokenizer #(
  parameter int LINE_WIDTH = ltbt_pkg::LINE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  input  logic                         in_at_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   out_token_kind,
  output logic [15:0]                  out_line_number,
  output logic [7:0]                   out_name_char,
  output logic                         out_last_of_run,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltbt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ltbt_pkg::*;

  `include "lambda_term_byte_tokenizer_macros.svh"

  cfg_wr_t              cfg_wr;
  tok_t [MAX_RES-1:0]   res;
  logic [RES_CNT_W-1:0] res_cnt;
  tok_t                 head;
  logic                 no_room;
  logic                 acc_in;
  logic                 pop;

  assign in_stall = no_room;
  assign acc_in   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  ltbt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_wr  (cfg_wr)
  );

  ltbt_scan #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (acc_in),
    .in_byte   (in_byte),
    .in_at_end (in_at_end),
    .cfg_wr    (cfg_wr),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  ltbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push_data (res),
    .pop       (pop),
    .head_vld  (out_valid),
    .head      (head),
    .no_room   (no_room)
  );

  assign out_token_kind  = head.kind;
  assign out_line_number = head.line;
  assign out_name_char   = head.ch;
  assign out_last_of_run = head.last;

  `LTBT_ASSERT_NXT(a_end_gives_result, acc_in && in_at_end, out_valid, "end item gave no result")
  `LTBT_ASSERT_IMP(a_end_is_last, out_valid && (out_token_kind == TK_END), out_last_of_run, "end token not last of run")
  `LTBT_ASSERT_IMP(a_char_zero, out_valid && (out_token_kind != TK_NAMEBYTE), out_name_char == 8'h00, "name char set on non-name token")

endmodule

// ----- hdl/ltbt_cfg.sv -----
module ltbt_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltbt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ltbt_pkg::cfg_wr_t            cfg_wr
);
  import ltbt_pkg::*;

  logic [15:0] first_line_r;
  logic [0:0]  reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready = 1'b1;

  assign cfg_wr.en    = psel && penable && pwrite && (reg_idx == REG_FIRST_LINE);
  assign cfg_wr.value = pwdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= FIRST_LINE_RST;
    end else if (cfg_wr.en) begin
      first_line_r <= cfg_wr.value;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIRST_LINE: prdata = {16'b0, first_line_r};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- hdl/ltbt_scan.sv -----
module ltbt_scan #(
  parameter int LINE_WIDTH = ltbt_pkg::LINE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    step,
  input  logic [7:0]                              in_byte,
  input  logic                                    in_at_end,
  input  ltbt_pkg::cfg_wr_t                       cfg_wr,
  output ltbt_pkg::tok_t [ltbt_pkg::MAX_RES-1:0]  res,
  output logic [ltbt_pkg::RES_CNT_W-1:0]          res_cnt
);
  import ltbt_pkg::*;

  scan_mode_t            mode_r, mode_nxt;
  logic                  bad_r, bad_nxt;
  logic [15:0]           start_r, start_nxt;
  logic [LINE_WIDTH-1:0] count_r, count_nxt;

  logic [LINE_WIDTH+15:0] lc_ext, rst_ext, wr_ext;
  logic [15:0]            lc;

  logic        blank_hit, delim_hit, is_cont;
  logic        idl_emit, idl_open, idl_bad, idl_inc;
  token_kind_t idl_kind;
  logic [7:0]  idl_ch;
  scan_mode_t  idl_mode;
  token_kind_t close_kind;

  logic                         apply_idle;
  tok_t [MAX_RES-1:0]           res_v;
  logic [RES_CNT_W-1:0]         n_v;

  function automatic tok_t mk(token_kind_t k, logic [15:0] ln, logic [7:0] ch);
    tok_t t;
    t.kind = k;
    t.line = ln;
    t.ch   = ch;
    t.last = 1'b0;
    return t;
  endfunction

  assign lc_ext  = {16'b0, count_r};
  assign lc      = lc_ext[15:0];
  assign rst_ext = {{LINE_WIDTH{1'b0}}, FIRST_LINE_RST};
  assign wr_ext  = {{LINE_WIDTH{1'b0}}, cfg_wr.value};

  assign blank_hit = (in_byte == BYTE_SP) || (in_byte == BYTE_TAB) || (in_byte == BYTE_CR) ||
                     (in_byte == BYTE_FF) || (in_byte == BYTE_VT);
  assign delim_hit = blank_hit || (in_byte == BYTE_LF) || (in_byte == BYTE_DOT) ||
                     (in_byte == BYTE_LPAR) || (in_byte == BYTE_RPAR) ||
                     (in_byte == BYTE_BSL) || (in_byte == BYTE_EQ);
  assign is_cont  = (in_byte >= CONT_LOW) && (in_byte <= CONT_HIGH);
  assign close_kind = bad_r ? TK_DIGITNAME : TK_NAMEEND;

  // byte seen between tokens
  always_comb begin
    idl_emit = 1'b0;
    idl_kind = TK_END;
    idl_ch   = '0;
    idl_mode = MODE_IDLE;
    idl_open = 1'b0;
    idl_bad  = 1'b0;
    idl_inc  = 1'b0;
    unique case (in_byte) inside
      BYTE_SP, BYTE_TAB, BYTE_CR, BYTE_FF, BYTE_VT: ;
      BYTE_LF: begin
        idl_emit = 1'b1;
        idl_kind = TK_NEWLINE;
        idl_inc  = 1'b1;
      end
      BYTE_HASH: idl_mode = MODE_COMMENT;
      BYTE_DOT: begin
        idl_emit = 1'b1;
        idl_kind = TK_DOT;
      end
      BYTE_LPAR: begin
        idl_emit = 1'b1;
        idl_kind = TK_LPAREN;
      end
      BYTE_RPAR: begin
        idl_emit = 1'b1;
        idl_kind = TK_RPAREN;
      end
      BYTE_EQ: begin
        idl_emit = 1'b1;
        idl_kind = TK_EQUALS;
      end
      BYTE_BSL: begin
        idl_emit = 1'b1;
        idl_kind = TK_LAMBDA;
      end
      LEAD_BYTE: idl_mode = MODE_IDLE_CE;
      [BYTE_ZERO:BYTE_NINE]: begin
        idl_mode = MODE_NAME;
        idl_open = 1'b1;
        idl_bad  = 1'b1;
      end
      default: begin
        idl_emit = 1'b1;
        idl_kind = TK_NAMEBYTE;
        idl_ch   = in_byte;
        idl_mode = MODE_NAME;
        idl_open = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    bad_nxt    = bad_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    apply_idle = 1'b0;
    if (step) begin
      if (in_at_end) begin
        mode_nxt = MODE_IDLE;
        if (mode_r == MODE_NAME || mode_r == MODE_NAME_CE) begin
          bad_nxt = 1'b0;
        end
      end else begin
        unique case (mode_r)
          MODE_COMMENT: apply_idle = (in_byte == BYTE_LF);
          MODE_IDLE_CE: begin
            if (in_byte == TAIL_BYTE) begin
              mode_nxt = MODE_IDLE;
            end else if (is_cont) begin
              mode_nxt  = MODE_NAME;
              start_nxt = lc;
              bad_nxt   = 1'b0;
            end else begin
              apply_idle = 1'b1;
            end
          end
          MODE_NAME: begin
            if (delim_hit) begin
              bad_nxt    = 1'b0;
              apply_idle = 1'b1;
            end else if (in_byte == LEAD_BYTE) begin
              mode_nxt = MODE_NAME_CE;
            end
          end
          MODE_NAME_CE: begin
            if (in_byte == TAIL_BYTE) begin
              bad_nxt  = 1'b0;
              mode_nxt = MODE_IDLE;
            end else if (is_cont) begin
              mode_nxt = MODE_NAME;
            end else begin
              bad_nxt    = 1'b0;
              apply_idle = 1'b1;
            end
          end
          default: apply_idle = 1'b1;
        endcase
      end
      if (apply_idle) begin
        mode_nxt = idl_mode;
        if (idl_open) begin
          start_nxt = lc;
          bad_nxt   = idl_bad;
        end
        if (idl_inc) begin
          count_nxt = count_r + LINE_WIDTH'(1);
        end
      end
    end
    if (cfg_wr.en) begin
      count_nxt = wr_ext[LINE_WIDTH-1:0];
    end
  end

  // results of this item
  always_comb begin
    res_v = '0;
    n_v   = '0;
    if (in_at_end) begin
      if (mode_r == MODE_IDLE_CE || mode_r == MODE_NAME_CE) begin
        res_v[n_v] = mk(TK_TRUNC, lc, 8'h00);
        n_v = n_v + 2'd1;
      end
      if (mode_r == MODE_NAME || mode_r == MODE_NAME_CE) begin
        res_v[n_v] = mk(close_kind, start_r, 8'h00);
        n_v = n_v + 2'd1;
      end
      res_v[n_v] = mk(TK_END, lc, 8'h00);
      n_v = n_v + 2'd1;
    end else begin
      unique case (mode_r)
        MODE_COMMENT: begin
          if (in_byte == BYTE_LF && idl_emit) begin
            res_v[n_v] = mk(idl_kind, lc, idl_ch);
            n_v = n_v + 2'd1;
          end
        end
        MODE_IDLE_CE: begin
          if (in_byte == TAIL_BYTE) begin
            res_v[n_v] = mk(TK_LAMBDA, lc, 8'h00);
            n_v = n_v + 2'd1;
          end else if (is_cont) begin
            res_v[n_v] = mk(TK_NAMEBYTE, lc, LEAD_BYTE);
            n_v = n_v + 2'd1;
            res_v[n_v] = mk(TK_NAMEBYTE, lc, in_byte);
            n_v = n_v + 2'd1;
          end else begin
            res_v[n_v] = mk(TK_TRUNC, lc, 8'h00);
            n_v = n_v + 2'd1;
            if (idl_emit) begin
              res_v[n_v] = mk(idl_kind, lc, idl_ch);
              n_v = n_v + 2'd1;
            end
          end
        end
        MODE_NAME: begin
          if (delim_hit) begin
            res_v[n_v] = mk(close_kind, start_r, 8'h00);
            n_v = n_v + 2'd1;
            if (idl_emit) begin
              res_v[n_v] = mk(idl_kind, lc, idl_ch);
              n_v = n_v + 2'd1;
            end
          end else if (in_byte != LEAD_BYTE && !bad_r) begin
            res_v[n_v] = mk(TK_NAMEBYTE, lc, in_byte);
            n_v = n_v + 2'd1;
          end
        end
        MODE_NAME_CE: begin
          if (in_byte == TAIL_BYTE) begin
            res_v[n_v] = mk(close_kind, start_r, 8'h00);
            n_v = n_v + 2'd1;
            res_v[n_v] = mk(TK_LAMBDA, lc, 8'h00);
            n_v = n_v + 2'd1;
          end else if (is_cont) begin
            if (!bad_r) begin
              res_v[n_v] = mk(TK_NAMEBYTE, lc, LEAD_BYTE);
              n_v = n_v + 2'd1;
              res_v[n_v] = mk(TK_NAMEBYTE, lc, in_byte);
              n_v = n_v + 2'd1;
            end
          end else begin
            res_v[n_v] = mk(TK_TRUNC, lc, 8'h00);
            n_v = n_v + 2'd1;
            res_v[n_v] = mk(close_kind, start_r, 8'h00);
            n_v = n_v + 2'd1;
            if (idl_emit) begin
              res_v[n_v] = mk(idl_kind, lc, idl_ch);
              n_v = n_v + 2'd1;
            end
          end
        end
        default: begin
          if (idl_emit) begin
            res_v[n_v] = mk(idl_kind, lc, idl_ch);
            n_v = n_v + 2'd1;
          end
        end
      endcase
    end
    if (n_v != '0) begin
      res_v[n_v - 2'd1].last = 1'b1;
    end
    res     = res_v;
    res_cnt = step ? n_v : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      bad_r   <= 1'b0;
      start_r <= '0;
      count_r <= rst_ext[LINE_WIDTH-1:0];
    end else begin
      mode_r  <= mode_nxt;
      bad_r   <= bad_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/ltbt_fifo.sv -----
module ltbt_fifo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [ltbt_pkg::RES_CNT_W-1:0]         push_cnt,
  input  ltbt_pkg::tok_t [ltbt_pkg::MAX_RES-1:0] push_data,
  input  logic                                   pop,
  output logic                                   head_vld,
  output ltbt_pkg::tok_t                         head,
  output logic                                   no_room
);
  import ltbt_pkg::*;

  tok_t              mem [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_vld = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  // hold the input unless a full item's worth of results fits
  assign no_room  = (count_r > QCNT_W'(QDEPTH - MAX_RES));

  assign wr_ptr_nxt = wr_ptr_r + QAW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  assign count_nxt  = count_r + QCNT_W'(push_cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_cnt) begin
        mem[wr_ptr_r + QAW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- dv/lambda_term_byte_tokenizer_tb.sv -----
module lambda_term_byte_tokenizer_tb;
  import ltbt_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam logic [PADDR_W-1:0] FIRST_LINE_ADDR = PADDR_W'(4 * REG_FIRST_LINE);

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic in_at_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_token_kind;
  logic [15:0] out_line_number;
  logic [7:0] out_name_char;
  logic out_last_of_run;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scan_mode_t scan_st = MODE_IDLE;
  logic swallow_name = 1'b0;
  logic [15:0] name_line = '0;
  logic [15:0] cur_line = FIRST_LINE_RST;
  logic [15:0] first_line_reg = FIRST_LINE_RST;
  tok_t tokens_due[$];
  tok_t step_toks[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [7:0] stall_tick = '0;
  stall_style_t stall_style = STALL_NONE;

  lambda_term_byte_tokenizer u_dut (.*);

  initial forever #5 clk = ~clk;

  function automatic bit blank_chk(logic [7:0] c);
    return c == BYTE_SP || c == BYTE_TAB || c == BYTE_CR || c == BYTE_FF || c == BYTE_VT;
  endfunction

  function automatic bit delim_chk(logic [7:0] c);
    return blank_chk(c) || c == BYTE_LF || c == BYTE_DOT || c == BYTE_LPAR ||
           c == BYTE_RPAR || c == BYTE_BSL || c == BYTE_EQ;
  endfunction

  function automatic bit is_cont(logic [7:0] c);
    return c >= CONT_LOW && c <= CONT_HIGH;
  endfunction

  function automatic void push_tok(token_kind_t k, logic [15:0] ln, logic [7:0] c);
    tok_t t;
    t.kind = k;
    t.line = ln;
    t.ch = c;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void close_name();
    if (swallow_name) push_tok(TK_DIGITNAME, name_line, 8'h00);
    else push_tok(TK_NAMEEND, name_line, 8'h00);
    swallow_name = 1'b0;
    scan_st = MODE_IDLE;
  endfunction

  function automatic void open_name(bit digit_led);
    name_line = cur_line;
    swallow_name = digit_led;
    scan_st = MODE_NAME;
  endfunction

  function automatic void between_tokens(logic [7:0] c);
    scan_st = MODE_IDLE;
    if (blank_chk(c)) return;
    case (c)
      BYTE_LF: begin
        push_tok(TK_NEWLINE, cur_line, 8'h00);
        cur_line = cur_line + 16'd1;
      end
      BYTE_HASH: scan_st = MODE_COMMENT;
      BYTE_DOT: push_tok(TK_DOT, cur_line, 8'h00);
      BYTE_LPAR: push_tok(TK_LPAREN, cur_line, 8'h00);
      BYTE_RPAR: push_tok(TK_RPAREN, cur_line, 8'h00);
      BYTE_EQ: push_tok(TK_EQUALS, cur_line, 8'h00);
      BYTE_BSL: push_tok(TK_LAMBDA, cur_line, 8'h00);
      LEAD_BYTE: scan_st = MODE_IDLE_CE;
      default: begin
        if (c >= BYTE_ZERO && c <= BYTE_NINE) begin
          open_name(1'b1);
        end else begin
          open_name(1'b0);
          push_tok(TK_NAMEBYTE, cur_line, c);
        end
      end
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic at_end);
    scan_mode_t mode;
    tok_t t;
    mode = scan_st;
    step_toks.delete();
    if (at_end) begin
      if (mode == MODE_IDLE_CE || mode == MODE_NAME_CE) push_tok(TK_TRUNC, cur_line, 8'h00);
      if (mode == MODE_NAME || mode == MODE_NAME_CE) close_name();
      push_tok(TK_END, cur_line, 8'h00);
      scan_st = MODE_IDLE;
    end else begin
      case (mode)
        MODE_COMMENT: if (c == BYTE_LF) between_tokens(c);
        MODE_IDLE_CE: begin
          if (c == TAIL_BYTE) begin
            push_tok(TK_LAMBDA, cur_line, 8'h00);
            scan_st = MODE_IDLE;
          end else if (is_cont(c)) begin
            open_name(1'b0);
            push_tok(TK_NAMEBYTE, cur_line, LEAD_BYTE);
            push_tok(TK_NAMEBYTE, cur_line, c);
          end else begin
            push_tok(TK_TRUNC, cur_line, 8'h00);
            between_tokens(c);
          end
        end
        MODE_NAME: begin
          if (delim_chk(c)) begin
            close_name();
            between_tokens(c);
          end else if (c == LEAD_BYTE) begin
            scan_st = MODE_NAME_CE;
          end else if (!swallow_name) begin
            push_tok(TK_NAMEBYTE, cur_line, c);
          end
        end
        MODE_NAME_CE: begin
          if (c == TAIL_BYTE) begin
            close_name();
            push_tok(TK_LAMBDA, cur_line, 8'h00);
          end else if (is_cont(c)) begin
            scan_st = MODE_NAME;
            if (!swallow_name) begin
              push_tok(TK_NAMEBYTE, cur_line, LEAD_BYTE);
              push_tok(TK_NAMEBYTE, cur_line, c);
            end
          end else begin
            push_tok(TK_TRUNC, cur_line, 8'h00);
            close_name();
            between_tokens(c);
          end
        end
        default: between_tokens(c);
      endcase
    end
    if (step_toks.size() > 0) begin
      t = step_toks[step_toks.size() - 1];
      t.last = 1'b1;
      step_toks[step_toks.size() - 1] = t;
    end
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [7:0] b, input logic at_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    in_at_end <= at_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(b, at_end);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tokens_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIRST_LINE_ADDR;
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    first_line_reg = v;
    cur_line = v;
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h61, 8'h7a));
    do c = 8'($urandom_range(0, 255)); while (delim_chk(c) || c == LEAD_BYTE);
    return c;
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(0, 4))
      0: return BYTE_DOT;
      1: return BYTE_LPAR;
      2: return BYTE_RPAR;
      3: return BYTE_EQ;
      default: return BYTE_BSL;
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return BYTE_SP;
      1: return BYTE_TAB;
      2: return BYTE_CR;
      3: return BYTE_FF;
      default: return BYTE_VT;
    endcase
  endfunction

  task automatic send_fragment();
    int pick;
    int len;
    int i;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(LEAD_BYTE, 1'b0);
          send_item(8'($urandom_range(CONT_LOW, CONT_HIGH)), 1'b0);
        end else begin
          send_item(name_byte(), 1'b0);
        end
      end
    end else if (pick < 38) begin
      send_item(8'($urandom_range(BYTE_ZERO, BYTE_NINE)), 1'b0);
      len = $urandom_range(0, 4);
      for (i = 0; i < len; i++) send_item(name_byte(), 1'b0);
    end else if (pick < 58) begin
      send_item(punct_byte(), 1'b0);
    end else if (pick < 68) begin
      send_item(blank_byte(), 1'b0);
    end else if (pick < 76) begin
      send_item(BYTE_LF, 1'b0);
    end else if (pick < 82) begin
      send_item(LEAD_BYTE, 1'b0);
      send_item(TAIL_BYTE, 1'b0);
    end else if (pick < 87) begin
      send_item(BYTE_HASH, 1'b0);
      len = $urandom_range(0, 5);
      for (i = 0; i < len; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == BYTE_LF);
        send_item(c, 1'b0);
      end
      send_item(BYTE_LF, 1'b0);
    end else if (pick < 92) begin
      send_item(LEAD_BYTE, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 98) begin
      len = $urandom_range(1, 3);
      for (i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_punctuation();
    send_item(BYTE_DOT, 1'b0);
    send_item(BYTE_LPAR, 1'b0);
    send_item(BYTE_TAB, 1'b0);
    send_item(BYTE_RPAR, 1'b0);
    send_item(BYTE_EQ, 1'b0);
    send_item(BYTE_VT, 1'b0);
    send_item(BYTE_BSL, 1'b0);
    send_item(BYTE_LF, 1'b0);
  endtask

  task automatic test_names();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(BYTE_CR, 1'b0);
    send_item(BYTE_NINE, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(CONT_LOW, 1'b0);
    send_item(BYTE_FF, 1'b0);
  endtask

  task automatic test_utf8_pairs();
    send_item(LEAD_BYTE, 1'b0);
    send_item(TAIL_BYTE, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(CONT_HIGH, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(TAIL_BYTE, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(BYTE_LPAR, 1'b0);
    send_item(BYTE_ZERO, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(BYTE_SP, 1'b0);
  endtask

  task automatic test_comment_and_end();
    send_item(BYTE_HASH, 1'b0);
    send_item(LEAD_BYTE, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(LEAD_BYTE, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h71, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_random_text(input int n_items, input logic [15:0] first_line);
    int start;
    wait_drained();
    write_first_line(first_line);
    start = items_sent;
    while (items_sent - start < n_items) send_fragment();
  endtask

  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected token kind %0d line %0d",
                                out_token_kind, out_line_number));
      end else begin
        want = tokens_due.pop_front();
        if (out_token_kind != want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_token_kind, want.kind));
        if (out_line_number != want.line)
          flag_mismatch($sformatf("line %0d, want %0d", out_line_number, want.line));
        if (out_name_char != want.ch)
          flag_mismatch($sformatf("name byte %02h, want %02h", out_name_char, want.ch));
        if (out_last_of_run != want.last)
          flag_mismatch($sformatf("last flag %0b, want %0b", out_last_of_run, want.last));
      end
    end
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_tick[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lambda_term_byte_tokenizer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_punctuation();
    test_names();
    test_utf8_pairs();
    test_comment_and_end();
    test_random_text(84, 16'hFFFF);
    test_random_text(84, 16'h0000);
    test_random_text(84, 16'($urandom_range(0, 65535)));
    test_random_text(84, 16'hFFFE);
    test_random_text(84, 16'($urandom_range(0, 65535)));
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lambda_term_byte_tokenizer_tb OK");
    end else begin
      $display("lambda_term_byte_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ltbt_pkg.sv
hdl/ltbt_cfg.sv
hdl/ltbt_scan.sv
hdl/ltbt_fifo.sv
hdl/lambda_term_byte_tokenizer.sv
dv/lambda_term_byte_tokenizer_tb.sv
